// ===== design/m4ta_pkg.sv =====
// ----------------------------------------------------------------------------
// m4ta_pkg
// Shared types and constants of the 4x4 transform matrix accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package m4ta_pkg;

	localparam int DATA_W = 32;
	localparam int FUNC_W = 3;
	localparam int IDX_W  = 4;
	localparam int ELEMS  = 16;
	localparam int ACC_W  = 67;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [FUNC_W-1:0]        func_t;
	typedef logic [IDX_W-1:0]         idx_t;

	localparam func_t FUNC_IDENT = 3'd0;
	localparam func_t FUNC_WR_M  = 3'd1;
	localparam func_t FUNC_WR_OP = 3'd2;
	localparam func_t FUNC_MUL   = 3'd3;
	localparam func_t FUNC_TRN   = 3'd4;
	localparam func_t FUNC_READ  = 3'd5;

	localparam idx_t ELEM_TX = 4'd12;
	localparam idx_t ELEM_TZ = 4'd14;

	localparam data_t DATA_MAX = 32'sh7fff_ffff;
	localparam data_t DATA_MIN = 32'sh8000_0000;

	localparam logic signed [ACC_W-1:0] ACC_MAX =
		{{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN =
		{{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== design/m4ta_ram.sv =====
// ----------------------------------------------------------------------------
// m4ta_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m4ta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/matrix4x4_transform_accumulator.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_transform_accumulator
// Column-major 4x4 fixed-point transform matrix with an operand matrix,
// multiply, translate, identity, element write and read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries func, index, value, trans_y and
//   trans_z; every transaction yields exactly one output transaction
//   (out_valid/out_stall) carrying read_value and saturated.
//   One item is worked at a time. An item is taken once the previous one has
//   moved into the output register, even while that result is still stalled.
//   Identity, element writes and unused codes go straight to the result;
//   read and translate first read matrix elements through the RAM, and a
//   multiply runs 64 multiply-accumulates through one shared 32x32
//   multiplier, one matrix and one operand memory read per cycle.
//   The matrix lives in two banks of one RAM; a multiply writes the other
//   bank and swaps banks at its end. Per-entry valid flags stand in for the
//   reset contents (identity matrix, zero operand), so reset takes effect at
//   once with no clearing pass. While out_stall is high the result holds and
//   a finished next item waits in place with in_stall high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix4x4_transform_accumulator
	import m4ta_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire func_t func,
	input  wire idx_t  index,
	input  wire data_t value,
	input  wire data_t trans_y,
	input  wire data_t trans_z,
	output logic       out_valid,
	input  wire logic  out_stall,
	output data_t      read_value,
	output logic       saturated
);

	localparam int CNT_W = 7;
	localparam int MAC_STEPS = 64;
	localparam int TRN_STEPS = 3;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_TRN  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_RES  = 3'd4;

	localparam data_t ONE_VAL = data_t'(1) <<< FRAC_BITS;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

	function automatic logic [DATA_W:0] clamp_fn(input logic signed [ACC_W-1:0] x);
		logic [DATA_W:0] r;
		if (x > ACC_MAX) begin
			r = {1'b1, DATA_MAX};
		end else if (x < ACC_MIN) begin
			r = {1'b1, DATA_MIN};
		end else begin
			r = {1'b0, x[DATA_W-1:0]};
		end
		return r;
	endfunction

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              bank_q;
	logic [1:0][ELEMS-1:0] mval_q;
	logic [ELEMS-1:0]  oval_q;
	logic              sat_q;
	func_t             func_q;
	idx_t              index_q;
	data_t             val_q;
	data_t             ty_q;
	data_t             tz_q;
	data_t             rd_q;
	logic signed [ACC_W-1:0] acc_q;

	logic              rd_s1;
	idx_t              maddr_s1;
	idx_t              e_s1;
	logic              last_s1;
	logic              mv_s1;
	logic              ov_s1;

	logic              mul_s2;
	logic              last_s2;
	idx_t              e_s2;
	logic signed [2*DATA_W-1:0] prod_s2;

	logic              out_valid_q;
	data_t             read_value_q;
	logic              saturated_q;

	logic              in_fire;
	logic              out_fire;
	logic              out_load;
	logic              issue;
	logic              last_k;
	idx_t              m_idx;
	idx_t              op_idx;

	data_t             m_rdata;
	data_t             op_rdata;
	data_t             m_val_s1;
	data_t             op_val_s1;

	logic signed [ACC_W-1:0] acc_total;
	logic signed [ACC_W-1:0] mac_shift;
	logic              mac_wr;
	logic              mac_sat;
	data_t             mac_res;

	data_t             trn_off;
	logic signed [DATA_W:0] trn_sum;
	logic              trn_wr;
	logic              trn_sat;
	data_t             trn_res;

	logic              m_we;
	logic [IDX_W:0]    m_waddr;
	data_t             m_wdata;
	logic              op_we;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_fire    = in_valid && !in_stall;
	assign out_fire   = out_valid_q && !out_stall;
	assign out_load   = (state_q == ST_RES) && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign saturated  = saturated_q;

	// read issue
	always_comb begin
		issue  = 1'b0;
		last_k = 1'b0;
		m_idx  = index_q;
		op_idx = '0;
		unique case (state_q)
			ST_MUL: begin
				issue  = (cnt_q < CNT_W'(MAC_STEPS));
				m_idx  = {cnt_q[1:0], cnt_q[3:2]};
				op_idx = {cnt_q[5:4], cnt_q[1:0]};
				last_k = (cnt_q[1:0] == 2'b11);
			end
			ST_TRN: begin
				issue = (cnt_q < CNT_W'(TRN_STEPS));
				m_idx = ELEM_TX + {2'b00, cnt_q[1:0]};
			end
			ST_RD: begin
				issue = (cnt_q == '0);
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	m4ta_ram #(
		.WIDTH(DATA_W),
		.DEPTH(2 * ELEMS)
	) u_mat_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.raddr({bank_q, m_idx}),
		.rdata(m_rdata)
	);

	m4ta_ram #(
		.WIDTH(DATA_W),
		.DEPTH(ELEMS)
	) u_op_ram (
		.clk  (clk),
		.we   (op_we),
		.waddr(index),
		.wdata(value),
		.raddr(op_idx),
		.rdata(op_rdata)
	);

	// entries never written since identity/reset
	assign m_val_s1  = mv_s1 ? m_rdata :
		((maddr_s1[1:0] == maddr_s1[3:2]) ? ONE_VAL : '0);
	assign op_val_s1 = ov_s1 ? op_rdata : '0;

	assign acc_total = acc_q + {{(ACC_W-2*DATA_W){prod_s2[2*DATA_W-1]}}, prod_s2};
	assign mac_shift = acc_total >>> FRAC_BITS;
	assign {mac_sat, mac_res} = clamp_fn(mac_shift);
	assign mac_wr = mul_s2 && last_s2;

	always_comb begin
		unique case (maddr_s1[1:0])
			2'd0:    trn_off = val_q;
			2'd1:    trn_off = ty_q;
			default: trn_off = tz_q;
		endcase
	end

	assign trn_sum = {m_val_s1[DATA_W-1], m_val_s1} + {trn_off[DATA_W-1], trn_off};
	assign {trn_sat, trn_res} =
		clamp_fn({{(ACC_W-DATA_W-1){trn_sum[DATA_W]}}, trn_sum});
	assign trn_wr = rd_s1 && (state_q == ST_TRN);

	assign op_we = in_fire && (func == FUNC_WR_OP);

	always_comb begin
		m_we    = 1'b0;
		m_waddr = {bank_q, index};
		m_wdata = value;
		priority if (in_fire && (func == FUNC_WR_M)) begin
			m_we = 1'b1;
		end else if (trn_wr) begin
			m_we    = 1'b1;
			m_waddr = {bank_q, maddr_s1};
			m_wdata = trn_res;
		end else if (mac_wr) begin
			m_we    = 1'b1;
			m_waddr = {~bank_q, e_s2};
			m_wdata = mac_res;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			bank_q      <= 1'b0;
			mval_q      <= '0;
			oval_q      <= '0;
			sat_q       <= 1'b0;
			rd_s1       <= 1'b0;
			mul_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1  <= issue;
			mul_s2 <= rd_s1 && (state_q == ST_MUL);
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (trn_wr) begin
				mval_q[bank_q][maddr_s1] <= 1'b1;
				sat_q <= sat_q | trn_sat;
			end
			if (mac_wr) begin
				mval_q[~bank_q][e_s2] <= 1'b1;
				sat_q <= sat_q | mac_sat;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q <= '0;
						sat_q <= 1'b0;
						unique case (func)
							FUNC_IDENT: begin
								mval_q[bank_q] <= '0;
								state_q <= ST_RES;
							end
							FUNC_WR_M: begin
								mval_q[bank_q][index] <= 1'b1;
								state_q <= ST_RES;
							end
							FUNC_WR_OP: begin
								oval_q[index] <= 1'b1;
								state_q <= ST_RES;
							end
							FUNC_MUL:  state_q <= ST_MUL;
							FUNC_TRN:  state_q <= ST_TRN;
							FUNC_READ: state_q <= ST_RD;
							default:   state_q <= ST_RES;
						endcase
					end
				end
				ST_MUL: begin
					if (mac_wr && (e_s2 == idx_t'(ELEMS - 1))) begin
						bank_q  <= ~bank_q;
						state_q <= ST_RES;
					end
				end
				ST_TRN: begin
					if (trn_wr && (maddr_s1 == ELEM_TZ)) begin
						state_q <= ST_RES;
					end
				end
				ST_RD: begin
					if (rd_s1) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q  <= func;
			index_q <= index;
			val_q   <= value;
			ty_q    <= trans_y;
			tz_q    <= trans_z;
			acc_q   <= HALF;
		end else if (mul_s2) begin
			acc_q <= last_s2 ? HALF : acc_total;
		end
		maddr_s1 <= m_idx;
		e_s1     <= cnt_q[5:2];
		last_s1  <= last_k;
		mv_s1    <= mval_q[bank_q][m_idx];
		ov_s1    <= oval_q[op_idx];
		prod_s2  <= m_val_s1 * op_val_s1;
		last_s2  <= last_s1;
		e_s2     <= e_s1;
		if ((state_q == ST_RD) && rd_s1) begin
			rd_q <= m_val_s1;
		end
		if (out_load) begin
			read_value_q <= (func_q == FUNC_READ) ? rd_q : '0;
			saturated_q  <= sat_q;
		end
	end

endmodule

`default_nettype wire

// ===== design/m4ta_checker.sv =====
// ----------------------------------------------------------------------------
// m4ta_checker
// Port-level checks of the 4x4 transform matrix accumulator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m4ta_checker
	import m4ta_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  in_valid,
	input wire logic  in_stall,
	input wire func_t func,
	input wire logic  out_valid,
	input wire logic  out_stall,
	input wire data_t read_value,
	input wire logic  saturated
);

	logic [1:0] pend_cnt_q;
	func_t      pend_q [2];
	logic       push;
	logic       pop;
	func_t      head;

	assign push = in_valid && !in_stall;
	assign pop  = out_valid && !out_stall;
	assign head = pend_q[0];

	// funcs of transactions still owed a result, oldest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
			pend_q[0]  <= FUNC_IDENT;
			pend_q[1]  <= FUNC_IDENT;
		end else begin
			unique case ({push, pop})
				2'b10: begin
					pend_q[pend_cnt_q[0]] <= func;
					pend_cnt_q <= pend_cnt_q + 1'b1;
				end
				2'b01: begin
					pend_q[0]  <= pend_q[1];
					pend_cnt_q <= pend_cnt_q - 1'b1;
				end
				2'b11: begin
					if (pend_cnt_q[1]) begin
						pend_q[0] <= pend_q[1];
						pend_q[1] <= func;
					end else begin
						pend_q[0] <= func;
					end
				end
				default: begin
					pend_cnt_q <= pend_cnt_q;
				end
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(saturated))
		else $error("output transaction changed while stalled");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> pend_cnt_q <= 2'd1)
		else $error("input taken while an item is still in work");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_cnt_q != 2'd0)
		else $error("output transaction without an input transaction");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (head != FUNC_READ) |-> read_value == '0)
		else $error("read_value nonzero for a non-read operation");

	a_sat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (head != FUNC_MUL) && (head != FUNC_TRN) |-> !saturated)
		else $error("saturated set for an operation that cannot clip");

endmodule

bind matrix4x4_transform_accumulator m4ta_checker u_m4ta_checker (.*);

`default_nettype wire

// ===== verif/matrix4x4_transform_accumulator_test.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_transform_accumulator_test
// Self-checking bench for the 4x4 transform matrix accumulator. A local
// predictor tracks the matrix and operand contents and works out the result
// of every accepted transaction. A checker compares each output transaction
// with the oldest expected result. Directed tests cover reset contents,
// unused codes, element extremes, translate overflow and multiply rounding
// and saturation. A long random mix follows, with random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix4x4_transform_accumulator_test;
	import m4ta_pkg::*;

	localparam int     FRAC     = 16;
	localparam data_t  UNITY    = 32'sd1 << FRAC;
	localparam func_t  FUNC_SPARE_LO = 3'd6;
	localparam func_t  FUNC_SPARE_HI = 3'd7;
	localparam int     RAND_ITEMS = 880;

	typedef struct packed {
		data_t read_value;
		logic  saturated;
	} result_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	func_t func;
	idx_t  index;
	data_t value;
	data_t trans_y;
	data_t trans_z;
	logic  out_valid;
	logic  out_stall;
	data_t read_value;
	logic  saturated;

	data_t   xform_matrix [ELEMS];
	data_t   operand_matrix [ELEMS];
	result_t pending_results [$];
	int      error_count = 0;
	int      stall_left = 0;
	bit      idle_on = 1'b1;

	matrix4x4_transform_accumulator #(.FRAC_BITS(FRAC)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.index      (index),
		.value      (value),
		.trans_y    (trans_y),
		.trans_z    (trans_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.saturated  (saturated)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic data_t clip(input logic signed [ACC_W-1:0] x, inout logic sat);
		if (x > ACC_MAX) begin
			sat = 1'b1;
			return DATA_MAX;
		end
		if (x < ACC_MIN) begin
			sat = 1'b1;
			return DATA_MIN;
		end
		return data_t'(x);
	endfunction

	function automatic void load_identity();
		for (int e = 0; e < ELEMS; e++) xform_matrix[e] = (e % 5 == 0) ? UNITY : '0;
	endfunction

	function automatic result_t apply_transform(func_t f, idx_t idx, data_t v, data_t y, data_t z);
		result_t                  r;
		data_t                    prev [ELEMS];
		data_t                    offs [3];
		logic signed [ACC_W-1:0]  acc;
		r.read_value = '0;
		r.saturated  = 1'b0;
		case (f)
			FUNC_IDENT: load_identity();
			FUNC_WR_M:  xform_matrix[idx] = v;
			FUNC_WR_OP: operand_matrix[idx] = v;
			FUNC_MUL: begin
				prev = xform_matrix;
				for (int c = 0; c < 4; c++) begin
					for (int rw = 0; rw < 4; rw++) begin
						acc = '0;
						for (int k = 0; k < 4; k++)
							acc = acc + prev[rw + 4 * k] * operand_matrix[k + 4 * c];
						acc = (acc + (ACC_W'(1) <<< (FRAC - 1))) >>> FRAC;
						xform_matrix[rw + 4 * c] = clip(acc, r.saturated);
					end
				end
			end
			FUNC_TRN: begin
				offs = '{v, y, z};
				for (int j = 0; j < 3; j++) begin
					acc = xform_matrix[ELEM_TX + j];
					acc = acc + offs[j];
					xform_matrix[ELEM_TX + j] = clip(acc, r.saturated);
				end
			end
			FUNC_READ: r.read_value = xform_matrix[idx];
			default: ;
		endcase
		return r;
	endfunction

	function automatic data_t rand_value();
		case ($urandom_range(0, 9))
			0: return DATA_MAX;
			1: return DATA_MIN;
			2, 3: return data_t'($urandom);
			default: return data_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
		endcase
	endfunction

	task automatic report_mismatch(string what, data_t got, data_t want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic send_item(func_t f, idx_t idx, data_t v, data_t y, data_t z);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		index    <= idx;
		value    <= v;
		trans_y  <= y;
		trans_z  <= z;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_transform(f, idx, v, y, z));
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected transaction, read_value", read_value, '0);
				end else begin
					want = pending_results.pop_front();
					if (read_value !== want.read_value)
						report_mismatch("read_value", read_value, want.read_value);
					if (saturated !== want.saturated)
						report_mismatch("saturated", data_t'(saturated), data_t'(want.saturated));
				end
				stall_left = idle_on ? $urandom_range(0, 5) : 0;
			end else if (out_valid && stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left > 0);
		end
	end

	task automatic test_reset_contents();
		send_item(FUNC_READ, 4'd0, rand_value(), rand_value(), rand_value());
		send_item(FUNC_READ, 4'd15, rand_value(), rand_value(), rand_value());
		send_item(FUNC_READ, 4'd1, rand_value(), rand_value(), rand_value());
	endtask

	task automatic test_unused_codes();
		send_item(FUNC_SPARE_LO, 4'd15, DATA_MAX, DATA_MIN, DATA_MAX);
		send_item(FUNC_SPARE_HI, 4'd0, DATA_MIN, DATA_MAX, DATA_MIN);
		send_item(FUNC_READ, 4'd10, '0, '0, '0);
	endtask

	task automatic test_element_extremes();
		send_item(FUNC_WR_M, 4'd3, DATA_MAX, '0, '0);
		send_item(FUNC_WR_M, 4'd15, DATA_MIN, '1, '1);
		send_item(FUNC_READ, 4'd3, '1, '1, '1);
		send_item(FUNC_READ, 4'd15, '0, '0, '0);
	endtask

	task automatic test_translate_overflow();
		send_item(FUNC_IDENT, 4'd7, DATA_MIN, DATA_MIN, DATA_MIN);
		send_item(FUNC_WR_M, ELEM_TX, DATA_MAX, '0, '0);
		send_item(FUNC_TRN, 4'd0, 32'sd1, DATA_MIN, DATA_MAX);
		send_item(FUNC_TRN, 4'd0, DATA_MIN, -32'sd1, 32'sd1);
		send_item(FUNC_READ, ELEM_TZ, '0, '0, '0);
	endtask

	task automatic test_multiply_rounding();
		send_item(FUNC_IDENT, 4'd0, '0, '0, '0);
		send_item(FUNC_WR_M, 4'd0, 32'sd1, '0, '0);
		send_item(FUNC_WR_M, 4'd1, -32'sd1, '0, '0);
		send_item(FUNC_WR_OP, 4'd0, 32'sd1 << (FRAC - 1), '0, '0);
		send_item(FUNC_WR_OP, 4'd5, DATA_MAX, '0, '0);
		send_item(FUNC_MUL, 4'd0, '0, '0, '0);
		send_item(FUNC_READ, 4'd0, '0, '0, '0);
		send_item(FUNC_READ, 4'd1, '0, '0, '0);
		send_item(FUNC_WR_M, 4'd5, DATA_MIN, '0, '0);
		send_item(FUNC_MUL, 4'd0, '0, '0, '0);
		send_item(FUNC_READ, 4'd5, '0, '0, '0);
	endtask

	task automatic test_random_mix(int count);
		int    sel;
		func_t f;
		for (int n = 0; n < count; n++) begin
			idle_on = (n % 150) < 110;
			if (n == count / 2)
				wait_results_drained();
			sel = $urandom_range(0, 99);
			if (sel < 30)      f = FUNC_WR_OP;
			else if (sel < 45) f = FUNC_WR_M;
			else if (sel < 57) f = FUNC_MUL;
			else if (sel < 67) f = FUNC_TRN;
			else if (sel < 87) f = FUNC_READ;
			else if (sel < 94) f = FUNC_IDENT;
			else if (sel < 97) f = FUNC_SPARE_LO;
			else               f = FUNC_SPARE_HI;
			send_item(f, idx_t'($urandom_range(0, 15)), rand_value(), rand_value(),
				rand_value());
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		func      <= FUNC_IDENT;
		index     <= '0;
		value     <= '0;
		trans_y   <= '0;
		trans_z   <= '0;
		load_identity();
		for (int e = 0; e < ELEMS; e++) operand_matrix[e] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_contents();
		test_unused_codes();
		test_element_extremes();
		test_translate_overflow();
		test_multiply_rounding();
		wait_results_drained();
		test_random_mix(RAND_ITEMS);

		wait_results_drained();
		repeat (80) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
